@@ src/assert_macros.svh @@
// Assertion macros for the allocator RTL.
// Expands to concurrent assertions in simulation and to nothing in synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every rising edge outside reset
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that a condition never holds outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (!(cond))) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

@@ src/ptba_pkg.sv @@
// Package of the per-thread block allocator: sizes, status codes, queue entry type.
// Used by every module of the block; depends on nothing.
package ptba_pkg;

    // Pool geometry; all three sizes are powers of two
    localparam int SECTIONS     = 64;
    localparam int BLOCKS_TOTAL = 4096;
    localparam int BLOCK_BYTES  = 4096;
    localparam int PER_SECTION  = BLOCKS_TOTAL / SECTIONS;

    localparam int ADDR_W = 48;
    localparam int TID_W  = 22;
    localparam int SEC_W  = $clog2(SECTIONS);
    localparam int SLOT_W = $clog2(PER_SECTION);
    localparam int CNT_W  = $clog2(PER_SECTION + 1);
    localparam int NSEC_W = $clog2(SECTIONS + 1);
    localparam int OFS_W  = $clog2(BLOCK_BYTES);
    localparam int BLK_W  = SEC_W + SLOT_W;
    localparam int POOL_W = OFS_W + BLK_W;

    // Depth of the queue between classifier and list engine
    localparam int Q_DEPTH = 2;
    localparam int QPTR_W  = $clog2(Q_DEPTH);
    localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

    // Command codes
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_EMPTY   = 3'd1,
        ST_NOSECT  = 3'd2,
        ST_BADADDR = 3'd3,
        ST_FULL    = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        OP_ALLOC,
        OP_FREE,
        OP_FAIL
    } t_kind;

    // Classified operation handed to the list engine
    typedef struct packed {
        t_kind              kind;
        t_status            status;
        logic [SEC_W-1:0]   sec;
        logic [SLOT_W-1:0]  slot;
    } t_op;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_flags;

endpackage

@@ src/ptba_front.sv @@
// Front end of the allocator: takes commands, owns the thread tag table,
// checks free addresses and pushes classified operations. Uses ptba_pkg.
module ptba_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    output logic                          o_busy,
    input  logic                          i_command,
    input  logic [ptba_pkg::TID_W-1:0]    i_thread_id,
    input  logic [ptba_pkg::ADDR_W-1:0]   i_block_address,
    input  logic [ptba_pkg::ADDR_W-1:0]   i_buffer_base,
    output logic                          o_push,
    output ptba_pkg::t_op                 o_op,
    input  ptba_pkg::t_q_flags            i_q_flags
);
    import ptba_pkg::*;

    typedef enum logic [1:0] {
        F_IDLE,
        F_MATCH,
        F_BIND
    } t_fstate;

    t_fstate              r_state;
    logic                 r_cmd;
    logic [TID_W-1:0]     r_tid;
    logic [ADDR_W-1:0]    r_addr;
    logic [ADDR_W:0]      r_diff;
    logic [SECTIONS-1:0]  r_match;
    logic [TID_W-1:0]     r_tags [SECTIONS];
    logic [SECTIONS-1:0]  r_tag_valid;
    logic [NSEC_W-1:0]    r_next_sec;

    logic                 accept;
    logic [SECTIONS-1:0]  match;
    logic                 found;
    logic [SEC_W-1:0]     found_sec;
    logic                 bind_new;
    logic                 bad_addr;
    t_op                  op;

    assign o_busy = (r_state != F_IDLE);
    assign accept = i_start && !o_busy;

    // Compare the thread id against every live tag
    always_comb begin
        for (int i = 0; i < SECTIONS; i++) begin
            match[i] = r_tag_valid[i] && (r_tags[i] == r_tid);
        end
    end

    // Encode the registered match; ids are unique so at most one bit is set
    always_comb begin
        found_sec = '0;
        for (int i = 0; i < SECTIONS; i++) begin
            if (r_match[i]) begin
                found_sec = found_sec | SEC_W'(i);
            end
        end
        found = |r_match;
    end

    // Address checks: below base, beyond pool, off a block boundary
    assign bad_addr = r_diff[ADDR_W] || (r_diff[ADDR_W-1:POOL_W] != '0)
                      || (r_diff[OFS_W-1:0] != '0);

    // Classify the command
    always_comb begin
        op.kind   = OP_FAIL;
        op.status = ST_OK;
        op.sec    = '0;
        op.slot   = '0;
        bind_new  = 1'b0;
        if (r_cmd == CMD_ALLOC) begin
            if (found) begin
                op.kind = OP_ALLOC;
                op.sec  = found_sec;
            end else if (r_next_sec == NSEC_W'(SECTIONS)) begin
                op.status = ST_NOSECT;
            end else begin
                op.kind  = OP_ALLOC;
                op.sec   = r_next_sec[SEC_W-1:0];
                bind_new = 1'b1;
            end
        end else begin
            if (bad_addr) begin
                op.status = ST_BADADDR;
            end else begin
                op.kind = OP_FREE;
                op.sec  = r_diff[POOL_W-1:OFS_W+SLOT_W];
                op.slot = r_diff[OFS_W+SLOT_W-1:OFS_W];
            end
        end
    end

    assign o_push = (r_state == F_BIND) && !i_q_flags.full;
    assign o_op   = op;

    // Sequencer, tag valid bits and section counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= F_IDLE;
            r_tag_valid <= '0;
            r_next_sec  <= '0;
        end else begin
            unique case (r_state)
                F_IDLE: begin
                    if (accept) begin
                        r_state <= F_MATCH;
                    end
                end
                F_MATCH: begin
                    r_state <= F_BIND;
                end
                F_BIND: begin
                    if (o_push) begin
                        r_state <= F_IDLE;
                        if (bind_new) begin
                            r_tag_valid[r_next_sec[SEC_W-1:0]] <= 1'b1;
                            r_next_sec <= r_next_sec + NSEC_W'(1);
                        end
                    end
                end
                default: begin
                    r_state <= F_IDLE;
                end
            endcase
        end
    end

    // Capture the command, the compare results and new tags
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd  <= i_command;
            r_tid  <= i_thread_id;
            r_addr <= i_block_address;
        end
        if (r_state == F_MATCH) begin
            r_match <= match;
            r_diff  <= {1'b0, r_addr} - {1'b0, i_buffer_base};
        end
        if (o_push && bind_new) begin
            r_tags[r_next_sec[SEC_W-1:0]] <= r_tid;
        end
    end

endmodule

@@ src/ptba_queue.sv @@
// Short operation queue between the allocator front end and list engine.
// Uses ptba_pkg for the entry type and depth.
module ptba_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  ptba_pkg::t_op         i_op,
    input  logic                  i_pop,
    output ptba_pkg::t_op         o_op,
    output ptba_pkg::t_q_flags    o_flags
);
    import ptba_pkg::*;

    t_op               r_mem [Q_DEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QCNT_W-1:0] r_cnt;

    assign o_flags.full  = (r_cnt == QCNT_W'(Q_DEPTH));
    assign o_flags.empty = (r_cnt == '0);
    assign o_op          = r_mem[r_rptr];

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == QPTR_W'(Q_DEPTH - 1)) ? '0 : r_wptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == QPTR_W'(Q_DEPTH - 1)) ? '0 : r_rptr + QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + QCNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - QCNT_W'(1);
            end
        end
    end

    // Store the entry
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_op;
        end
    end

endmodule

@@ src/ptba_back.sv @@
// List engine of the allocator: per-section ring pointers and free-slot memory,
// pops and pushes blocks and drives the result. Uses ptba_pkg, assert_macros.svh.
`include "assert_macros.svh"
module ptba_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ptba_pkg::t_op                 i_op,
    input  ptba_pkg::t_q_flags            i_q_flags,
    output logic                          o_pop,
    input  logic [ptba_pkg::ADDR_W-1:0]   i_buffer_base,
    output logic                          o_result_valid,
    output logic                          o_granted,
    output logic [ptba_pkg::ADDR_W-1:0]   o_granted_address,
    output ptba_pkg::t_status             o_status
);
    import ptba_pkg::*;

    typedef enum logic [1:0] {
        B_IDLE,
        B_META,
        B_SLOT
    } t_bstate;

    // Ring state of one section; fill counts pushes, saturating when all
    // entries of the ring have been written once
    typedef struct packed {
        logic [SLOT_W-1:0] head;
        logic [CNT_W-1:0]  count;
        logic [CNT_W-1:0]  fill;
    } t_meta;

    localparam t_meta META_RESET = '{head: '0, count: CNT_W'(PER_SECTION), fill: '0};

    t_bstate              r_state;
    t_op                  r_op;
    t_meta                r_meta_mem [SECTIONS];
    logic [SECTIONS-1:0]  r_meta_ok;
    t_meta                r_meta_q;
    logic                 r_meta_q_ok;
    logic [SLOT_W-1:0]    r_slots [BLOCKS_TOTAL];
    logic [SLOT_W-1:0]    r_slot_q;
    logic [SLOT_W-1:0]    r_pos;
    logic                 r_pos_ok;
    logic                 r_res_valid;
    logic                 r_granted;
    logic [ADDR_W-1:0]    r_res_addr;
    t_status              r_status;

    t_meta                meta;
    t_meta                meta_wdata;
    logic                 meta_we;
    logic                 meta_re;
    logic                 slot_we;
    logic                 slot_re;
    logic [SLOT_W-1:0]    tail_pos;
    logic [SLOT_W-1:0]    slot_sel;
    logic [ADDR_W-1:0]    alloc_addr;

    // Unwritten sections read as a full ring starting at slot zero
    assign meta = r_meta_q_ok ? r_meta_q : META_RESET;

    assign o_pop    = (r_state == B_IDLE) && !i_q_flags.empty;
    assign meta_re  = o_pop && (i_op.kind != OP_FAIL);
    assign tail_pos = meta.head + meta.count[SLOT_W-1:0];

    // Ring entries not yet written hold their own position
    assign slot_sel   = r_pos_ok ? r_slot_q : r_pos;
    assign alloc_addr = i_buffer_base
                        + ADDR_W'({r_op.sec, slot_sel, {OFS_W{1'b0}}});

    // Decide the memory updates for the section just read
    always_comb begin
        meta_we    = 1'b0;
        meta_wdata = meta;
        slot_we    = 1'b0;
        slot_re    = 1'b0;
        if (r_state == B_META) begin
            if (r_op.kind == OP_ALLOC) begin
                if (meta.count != '0) begin
                    slot_re          = 1'b1;
                    meta_we          = 1'b1;
                    meta_wdata.head  = meta.head + SLOT_W'(1);
                    meta_wdata.count = meta.count - CNT_W'(1);
                end
            end else begin
                if (meta.count < CNT_W'(PER_SECTION)) begin
                    slot_we          = 1'b1;
                    meta_we          = 1'b1;
                    meta_wdata.count = meta.count + CNT_W'(1);
                    if (meta.fill != CNT_W'(PER_SECTION)) begin
                        meta_wdata.fill = meta.fill + CNT_W'(1);
                    end
                end
            end
        end
    end

    // Sequencer, valid bits and result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_meta_ok   <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_res_valid <= 1'b0;
            if (meta_we) begin
                r_meta_ok[r_op.sec] <= 1'b1;
            end
            unique case (r_state)
                B_IDLE: begin
                    if (o_pop) begin
                        if (i_op.kind == OP_FAIL) begin
                            r_res_valid <= 1'b1;
                        end else begin
                            r_state <= B_META;
                        end
                    end
                end
                B_META: begin
                    if (slot_re) begin
                        r_state <= B_SLOT;
                    end else begin
                        r_state     <= B_IDLE;
                        r_res_valid <= 1'b1;
                    end
                end
                B_SLOT: begin
                    r_state     <= B_IDLE;
                    r_res_valid <= 1'b1;
                end
                default: begin
                    r_state <= B_IDLE;
                end
            endcase
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_op <= i_op;
            if (i_op.kind == OP_FAIL) begin
                r_granted  <= 1'b0;
                r_res_addr <= '0;
                r_status   <= i_op.status;
            end
        end
        if (r_state == B_META && !slot_re) begin
            r_granted  <= meta_we;
            r_res_addr <= '0;
            if (meta_we) begin
                r_status <= ST_OK;
            end else if (r_op.kind == OP_ALLOC) begin
                r_status <= ST_EMPTY;
            end else begin
                r_status <= ST_FULL;
            end
        end
        if (r_state == B_SLOT) begin
            r_granted  <= 1'b1;
            r_res_addr <= alloc_addr;
            r_status   <= ST_OK;
        end
        if (slot_re) begin
            r_pos    <= meta.head;
            r_pos_ok <= ({1'b0, meta.head} < meta.fill);
        end
    end

    // Section pointer memory
    always_ff @(posedge i_clk) begin
        if (meta_re) begin
            r_meta_q    <= r_meta_mem[i_op.sec];
            r_meta_q_ok <= r_meta_ok[i_op.sec];
        end
        if (meta_we) begin
            r_meta_mem[r_op.sec] <= meta_wdata;
        end
    end

    // Free-slot memory
    always_ff @(posedge i_clk) begin
        if (slot_re) begin
            r_slot_q <= r_slots[{r_op.sec, meta.head}];
        end
        if (slot_we) begin
            r_slots[{r_op.sec, tail_pos}] <= r_op.slot;
        end
    end

    assign o_result_valid    = r_res_valid;
    assign o_granted         = r_granted;
    assign o_granted_address = r_res_addr;
    assign o_status          = r_status;

    `ASSERT_PROP(a_grant_ok, i_clk, i_rst_n, r_res_valid && r_granted |-> r_status == ST_OK, "grant with error status")
    `ASSERT_PROP(a_fail_addr, i_clk, i_rst_n, r_res_valid && !r_granted |-> r_res_addr == '0, "failed result carries an address")
    `ASSERT_NEVER(a_pop_empty, i_clk, i_rst_n, o_pop && i_q_flags.empty, "pop from empty queue")
    `ASSERT_PROP(a_slot_result, i_clk, i_rst_n, r_state == B_SLOT |=> r_res_valid && r_granted, "slot read without grant")
    `ASSERT_PROP(a_count_bound, i_clk, i_rst_n, meta_we |-> meta_wdata.count <= CNT_W'(PER_SECTION), "ring count overflow")

endmodule

@@ src/per_thread_block_allocator.sv @@
// Top level of the per-thread block allocator: base register, front end,
// operation queue and list engine. Uses ptba_pkg, ptba_front, ptba_queue, ptba_back.
//
//  channel   direction  handshake                       payload
//  command   in         start && !busy                  i_command, i_thread_id,
//                                                       i_block_address
//  result    out        o_result_valid, one cycle       o_granted, o_granted_address,
//                                                       o_status
//  config    in         i_cfg_valid && o_cfg_ready      i_cfg_data (buffer_base)
//
// A new command is taken only once the front sequencer has stepped through take, tag
// compare and address subtract, and classify; busy also stays high while the queue is full.
// The list engine answers a rejected command straight from the queue, a free after the
// section pointer read, and an allocate after the section pointer read, slot read and
// address add; results follow in order.
// Reset clears the tag valid bits, section counter and per-section valid bits at once;
// there is no clearing pass. Results cannot be stalled.
module per_thread_block_allocator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_command,
    input  logic [ptba_pkg::TID_W-1:0]    i_thread_id,
    input  logic [ptba_pkg::ADDR_W-1:0]   i_block_address,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [ptba_pkg::ADDR_W-1:0]   i_cfg_data,
    output logic                          o_result_valid,
    output logic                          o_granted,
    output logic [ptba_pkg::ADDR_W-1:0]   o_granted_address,
    output logic [2:0]                    o_status
);
    import ptba_pkg::*;

    logic [ADDR_W-1:0] r_buffer_base;
    logic              push;
    logic              pop;
    t_op               push_op;
    t_op               head_op;
    t_q_flags          q_flags;
    t_status           status;

    // Base register, writable in any cycle
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buffer_base <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_buffer_base <= i_cfg_data;
        end
    end

    ptba_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .o_busy          (busy),
        .i_command       (i_command),
        .i_thread_id     (i_thread_id),
        .i_block_address (i_block_address),
        .i_buffer_base   (r_buffer_base),
        .o_push          (push),
        .o_op            (push_op),
        .i_q_flags       (q_flags)
    );

    ptba_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (push_op),
        .i_pop   (pop),
        .o_op    (head_op),
        .o_flags (q_flags)
    );

    ptba_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_op              (head_op),
        .i_q_flags         (q_flags),
        .o_pop             (pop),
        .i_buffer_base     (r_buffer_base),
        .o_result_valid    (o_result_valid),
        .o_granted         (o_granted),
        .o_granted_address (o_granted_address),
        .o_status          (status)
    );

    assign o_status = status;

endmodule

@@ test/testbench.sv @@
// Self-checking testbench of per_thread_block_allocator: directed and random alloc/free traffic.
// Keeps a mirror of the tag table and the per-section free lists and checks each result.
// Depends on ptba_pkg and the allocator RTL only.
module testbench;
    import ptba_pkg::*;

    typedef struct {
        logic              granted;
        logic [ADDR_W-1:0] address;
        t_status           status;
    } t_pool_outcome;

    // Mirror of the allocator: thread bindings, free rings and the results still due
    class free_list_mirror;
        logic [ADDR_W-1:0] base;
        bit                tag_used [SECTIONS];
        logic [TID_W-1:0]  tag_tid [SECTIONS];
        int                next_sec;
        int                ring [SECTIONS][PER_SECTION];
        int                head [SECTIONS];
        int                fill [SECTIONS];
        t_pool_outcome     due [$];
        int                errors;

        function new();
            base     = '0;
            next_sec = 0;
            errors   = 0;
            for (int s = 0; s < SECTIONS; s++) begin
                tag_used[s] = 1'b0;
                tag_tid[s]  = '0;
                head[s]     = 0;
                fill[s]     = PER_SECTION;
                for (int j = 0; j < PER_SECTION; j++)
                    ring[s][j] = j;
            end
        endfunction

        // Apply one accepted command and queue the result it must produce
        function t_pool_outcome take_request(input logic cmd, input logic [TID_W-1:0] tid,
                                             input logic [ADDR_W-1:0] addr, output int blk);
            t_pool_outcome     res;
            int                sec;
            int                idx;
            logic [ADDR_W-1:0] off;
            res.granted = 1'b0;
            res.address = '0;
            res.status  = ST_OK;
            blk         = -1;
            if (cmd == CMD_ALLOC) begin
                sec = -1;
                for (int i = 0; i < SECTIONS; i++)
                    if (sec < 0 && tag_used[i] && tag_tid[i] == tid)
                        sec = i;
                // bind a thread seen for the first time to the next unused section
                if (sec < 0 && next_sec < SECTIONS) begin
                    sec           = next_sec;
                    tag_used[sec] = 1'b1;
                    tag_tid[sec]  = tid;
                    next_sec++;
                end
                if (sec < 0)
                    res.status = ST_NOSECT;
                else if (fill[sec] == 0)
                    res.status = ST_EMPTY;
                else begin
                    blk         = sec * PER_SECTION + ring[sec][head[sec]];
                    head[sec]   = (head[sec] + 1) % PER_SECTION;
                    fill[sec]   = fill[sec] - 1;
                    res.granted = 1'b1;
                    res.address = base + ADDR_W'(blk) * ADDR_W'(BLOCK_BYTES);
                end
            end else begin
                off = addr - base;
                if (addr < base || off[ADDR_W-1:POOL_W] != 0 || off[OFS_W-1:0] != 0)
                    res.status = ST_BADADDR;
                else begin
                    idx = off[POOL_W-1:OFS_W];
                    sec = idx / PER_SECTION;
                    if (fill[sec] >= PER_SECTION)
                        res.status = ST_FULL;
                    else begin
                        // push at the tail of the section's ring
                        ring[sec][(head[sec] + fill[sec]) % PER_SECTION] = idx % PER_SECTION;
                        fill[sec]   = fill[sec] + 1;
                        res.granted = 1'b1;
                    end
                end
            end
            due.insert(due.size(), res);
            return res;
        endfunction

        task report_mismatch(input string what);
            $display("MISMATCH @%0t: %s", $realtime, what);
            errors++;
        endtask

        // Compare one result transfer with the oldest expectation
        task match_result(input logic granted, input logic [ADDR_W-1:0] address,
                          input logic [2:0] status);
            t_pool_outcome want;
            if (due.size() == 0) begin
                report_mismatch($sformatf("unexpected result granted=%0b addr=%h status=%0d",
                                          granted, address, status));
            end else begin
                want = due[0];
                due.delete(0);
                if (granted !== want.granted)
                    report_mismatch($sformatf("granted %0b, want %0b", granted, want.granted));
                if (address !== want.address)
                    report_mismatch($sformatf("address %h, want %h", address, want.address));
                if (status !== want.status)
                    report_mismatch($sformatf("status %0d, want %s", status,
                                              want.status.name()));
            end
        endtask

        task flag_leftovers();
            if (due.size() != 0)
                report_mismatch($sformatf("%0d results never arrived", due.size()));
        endtask
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic              i_command;
    logic [TID_W-1:0]  i_thread_id;
    logic [ADDR_W-1:0] i_block_address;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [ADDR_W-1:0] i_cfg_data;
    logic              o_result_valid;
    logic              o_granted;
    logic [ADDR_W-1:0] o_granted_address;
    logic [2:0]        o_status;

    free_list_mirror   mirror;
    int                held_blocks [$];
    logic [TID_W-1:0]  known_tids [$];

    per_thread_block_allocator i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_command         (i_command),
        .i_thread_id       (i_thread_id),
        .i_block_address   (i_block_address),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_data        (i_cfg_data),
        .o_result_valid    (o_result_valid),
        .o_granted         (o_granted),
        .o_granted_address (o_granted_address),
        .o_status          (o_status)
    );

    always #6 i_clk = ~i_clk;

    // Check every result transfer
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_result_valid === 1'b1)
            mirror.match_result(o_granted, o_granted_address, o_status);
    end

    function automatic logic [ADDR_W-1:0] random_address();
        return {16'($urandom), 32'($urandom)};
    endfunction

    function automatic logic [ADDR_W-1:0] block_address(input int idx);
        return mirror.base + ADDR_W'(idx) * ADDR_W'(BLOCK_BYTES);
    endfunction

    // Drive one command from a falling edge; return at the falling edge after its transfer
    task automatic issue(input logic cmd, input logic [TID_W-1:0] tid,
                         input logic [ADDR_W-1:0] addr, output t_pool_outcome got,
                         output int blk);
        start           <= 1'b1;
        i_command       <= cmd;
        i_thread_id     <= tid;
        i_block_address <= addr;
        do @(posedge i_clk); while (busy !== 1'b0);
        got = mirror.take_request(cmd, tid, addr, blk);
        @(negedge i_clk);
    endtask

    // Issue a command and track the blocks that threads hold
    task automatic run_command(input logic cmd, input logic [TID_W-1:0] tid,
                               input logic [ADDR_W-1:0] addr, input int picked);
        t_pool_outcome got;
        int            blk;
        issue(cmd, tid, addr, got, blk);
        if (blk >= 0)
            held_blocks.insert(held_blocks.size(), blk);
        if (cmd == CMD_FREE && picked >= 0 && got.granted)
            held_blocks.delete(picked);
    endtask

    // Drop start and wait until every result is back, then let the pipeline drain
    task automatic settle();
        start <= 1'b0;
        while (mirror.due.size() != 0)
            @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_base(input logic [ADDR_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        mirror.base = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Mostly the two hot threads, sometimes any known thread, now and then a new one
    function automatic logic [TID_W-1:0] pick_thread();
        logic [TID_W-1:0] t;
        if (known_tids.size() == 0 || $urandom_range(0, 99) < 8) begin
            t = TID_W'($urandom);
            known_tids.insert(known_tids.size(), t);
        end else if ($urandom_range(0, 99) < 70)
            t = known_tids[$urandom_range(0, known_tids.size() > 1 ? 1 : 0)];
        else
            t = known_tids[$urandom_range(0, known_tids.size() - 1)];
        return t;
    endfunction

    // Run a random phase of alloc/free traffic in bursts
    task automatic random_phase(input int count, input int alloc_pct);
        int                burst_left;
        int                gap;
        int                picked;
        int                r;
        logic              cmd;
        logic [TID_W-1:0]  tid;
        logic [ADDR_W-1:0] addr;
        burst_left = 0;
        for (int n = 0; n < count; n++) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
                if (gap > 0) begin
                    start           <= 1'b0;
                    i_command       <= 1'($urandom);
                    i_thread_id     <= TID_W'($urandom);
                    i_block_address <= random_address();
                    repeat (gap) @(negedge i_clk);
                end
            end
            burst_left--;
            picked = -1;
            if ($urandom_range(0, 99) < alloc_pct) begin
                cmd  = CMD_ALLOC;
                tid  = pick_thread();
                addr = random_address();
            end else begin
                cmd = CMD_FREE;
                tid = TID_W'($urandom);
                r   = $urandom_range(0, 99);
                if (r < 70 && held_blocks.size() > 0) begin
                    picked = $urandom_range(0, held_blocks.size() - 1);
                    addr   = block_address(held_blocks[picked]);
                end else if (r < 80)
                    addr = block_address($urandom_range(0, BLOCKS_TOTAL - 1));
                else if (r < 88)
                    addr = block_address($urandom_range(0, BLOCKS_TOTAL - 1))
                           + ADDR_W'($urandom_range(1, BLOCK_BYTES - 1));
                else if (r < 94)
                    addr = mirror.base - ADDR_W'($urandom_range(1, 1 << 20));
                else if (r < 97)
                    addr = block_address(BLOCKS_TOTAL + $urandom_range(0, 1 << 16));
                else
                    addr = random_address();
            end
            run_command(cmd, tid, addr, picked);
        end
    endtask

    // Stimulus
    initial begin
        logic [ADDR_W-1:0] phase_base [5];
        int                phase_alloc [5];
        logic [ADDR_W-1:0] rnd_base;
        mirror          = new();
        i_rst_n         = 1'b0;
        start           = 1'b0;
        i_command       = CMD_ALLOC;
        i_thread_id     = '0;
        i_block_address = '0;
        i_cfg_valid     = 1'b0;
        i_cfg_data      = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: base at zero, field extremes, double free, bad addresses
        write_base('0);
        known_tids.insert(known_tids.size(), '0);
        known_tids.insert(known_tids.size(), '1);
        known_tids.insert(known_tids.size(), 22'h2AAAAA);
        known_tids.insert(known_tids.size(), 22'h155555);
        run_command(CMD_ALLOC, '0, random_address(), -1);
        run_command(CMD_ALLOC, '1, '1, -1);
        run_command(CMD_ALLOC, '0, '0, -1);
        run_command(CMD_FREE, '1, 48'h0, -1);
        run_command(CMD_FREE, '0, 48'h0, -1);
        run_command(CMD_FREE, '0, 48'h0, -1);
        run_command(CMD_FREE, '0, 48'h1, -1);
        run_command(CMD_FREE, '0, 48'h100_0000, -1);
        run_command(CMD_FREE, '0, 48'hFF_F000, -1);
        run_command(CMD_FREE, '1, '1, -1);
        run_command(CMD_FREE, '0, 48'h41000, -1);
        run_command(CMD_ALLOC, '0, '0, -1);
        run_command(CMD_ALLOC, 22'h2AAAAA, 48'hAAAA_AAAA_AAAA, -1);
        run_command(CMD_ALLOC, 22'h155555, 48'h5555_5555_5555, -1);
        run_command(CMD_FREE, 22'h155555, 48'h1000, -1);
        run_command(CMD_FREE, '0, 48'hFFF, -1);

        // Random phases, each under its own pool base
        rnd_base       = random_address();
        phase_base[0]  = 48'h0000_0000_1000;
        phase_base[1]  = 48'hFFFF_FFFF_F000;
        phase_base[2]  = {rnd_base[ADDR_W-1:OFS_W], OFS_W'(0)};
        phase_base[3]  = 48'hFFFF_FF00_0000;
        phase_base[4]  = 48'h0;
        phase_alloc[0] = 55;
        phase_alloc[1] = 80;
        phase_alloc[2] = 40;
        phase_alloc[3] = 65;
        phase_alloc[4] = 50;
        for (int p = 0; p < 5; p++) begin
            settle();
            write_base(phase_base[p]);
            random_phase(400, phase_alloc[p]);
        end

        settle();
        mirror.flag_leftovers();
        if (mirror.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Watchdog
    initial begin
        #4_800_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
